// ===== rtl/psc_pkg.sv =====
// package for the pressure sensor compensation block: codes, control word and microcode rom
package psc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_SENS_BASE         = 3'd0;
   localparam logic [2:0] CSR_OFFSET_BASE       = 3'd1;
   localparam logic [2:0] CSR_SENS_TEMP_SLOPE   = 3'd2;
   localparam logic [2:0] CSR_OFFSET_TEMP_SLOPE = 3'd3;
   localparam logic [2:0] CSR_REFERENCE_TEMP    = 3'd4;
   localparam logic [2:0] CSR_TEMP_SLOPE        = 3'd5;

   // reading kinds
   localparam logic OP_TEMPERATURE = 1'b0;
   localparam logic OP_PRESSURE    = 1'b1;

   localparam logic signed [31:0] TEMP_BASE = 32'sd2000;

   localparam int STEP_W = 4;

   typedef enum logic {
      A_DT  = 1'b0,
      A_RAW = 1'b1
   } a_sel_type;

   typedef enum logic [2:0] {
      B_TEMP_SLOPE   = 3'd0,
      B_OFFSET_SLOPE = 3'd1,
      B_SENS_SLOPE   = 3'd2,
      B_SENS_LO      = 3'd3,
      B_SENS_HI      = 3'd4
   } b_sel_type;

   typedef enum logic [3:0] {
      ALU_NONE    = 4'd0,
      ALU_DT      = 4'd1,
      ALU_TEMP    = 4'd2,
      ALU_OFF     = 4'd3,
      ALU_SENS    = 4'd4,
      ALU_LOAD    = 4'd5,
      ALU_ADDHI   = 4'd6,
      ALU_SUBOFF  = 4'd7,
      ALU_FINAL   = 4'd8
   } alu_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT      = 2'd0,
      SEQ_JUMP_PRES = 2'd1,
      SEQ_LAST      = 2'd2
   } seq_op_type;

   typedef struct packed {
      a_sel_type          a_sel;
      b_sel_type          b_sel;
      logic               mul_en;
      alu_op_type         alu;
      seq_op_type         seq;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   localparam logic [STEP_W-1:0] PRES_ENTRY = 4'd4;

   // program: dispatch, temperature path (1..3), pressure path (4..11)
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      w = '{a_sel: A_DT, b_sel: B_TEMP_SLOPE, mul_en: 1'b0, alu: ALU_NONE,
            seq: SEQ_NEXT, target: '0};
      unique case (addr)
         4'd0:  begin w.seq = SEQ_JUMP_PRES; w.target = PRES_ENTRY; end
         4'd1:  w.alu = ALU_DT;
         4'd2:  begin w.mul_en = 1'b1; w.b_sel = B_TEMP_SLOPE; end
         4'd3:  begin w.alu = ALU_TEMP; w.seq = SEQ_LAST; end
         4'd4:  begin w.mul_en = 1'b1; w.b_sel = B_OFFSET_SLOPE; end
         4'd5:  begin w.alu = ALU_OFF; w.mul_en = 1'b1; w.b_sel = B_SENS_SLOPE; end
         4'd6:  w.alu = ALU_SENS;
         4'd7:  begin w.mul_en = 1'b1; w.a_sel = A_RAW; w.b_sel = B_SENS_LO; end
         4'd8:  begin
            w.alu = ALU_LOAD; w.mul_en = 1'b1; w.a_sel = A_RAW; w.b_sel = B_SENS_HI;
         end
         4'd9:  w.alu = ALU_ADDHI;
         4'd10: w.alu = ALU_SUBOFF;
         4'd11: begin w.alu = ALU_FINAL; w.seq = SEQ_LAST; end
         default: w.seq = SEQ_LAST;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/pressure_sensor_compensation.sv =====
// pressure sensor first-order compensation: microcoded sequencer over one shared multiplier
// throughput: one item at a time, a new item is taken the cycle after the previous result
//   is written to the output register; the shared 26x19 multiplier and the microcode step
//   counter serve one item at a time
// reset: synchronous active high, clears calibration words, stored dT, sequencer and rsp_tvalid
module pressure_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] raw_reading
   input  logic        req_tuser,   // [0] op
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic        rsp_tuser    // [0] kind
);

   localparam int SW = psc_pkg::STEP_W;
   localparam logic [31:0] TEMP_BASE_U = psc_pkg::TEMP_BASE;

   // calibration words
   logic [15:0] sens_base_ff, offset_base_ff, sens_slope_ff, off_slope_ff;
   logic [15:0] ref_temp_ff, temp_slope_ff;

   // sequencer state
   logic          busy_ff, busy_in;
   logic [SW-1:0] step_ff, step_in;
   psc_pkg::ucode_type uc;

   // captured item
   logic        op_ff;
   logic [23:0] raw_ff;

   // datapath registers
   logic signed [25:0] dt_ff, dt_in;
   logic signed [44:0] prod_ff, prod_in;
   logic signed [35:0] off_ff, off_in;
   logic signed [35:0] sens_ff, sens_in;
   logic signed [59:0] acc_ff, acc_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_kind_ff, rsp_kind_in;

   logic               accept;
   logic               run;
   logic               stall;
   logic               finish;
   logic signed [25:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [44:0] prod_sh7, prod_sh8, prod_sh23;
   logic signed [59:0] acc_sh15, acc_sh21;
   logic [31:0]        result;

   assign uc         = psc_pkg::ucode_rom(step_ff);
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   // the last step waits while the output register still holds an untaken result
   assign stall      = (uc.seq == psc_pkg::SEQ_LAST) && rsp_valid_ff && !rsp_tready;
   assign run        = busy_ff && !stall;
   assign finish     = run && (uc.seq == psc_pkg::SEQ_LAST);

   // calibration register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_base_ff   <= '0;
         offset_base_ff <= '0;
         sens_slope_ff  <= '0;
         off_slope_ff   <= '0;
         ref_temp_ff    <= '0;
         temp_slope_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            psc_pkg::CSR_SENS_BASE:         sens_base_ff   <= csr_wdata;
            psc_pkg::CSR_OFFSET_BASE:       offset_base_ff <= csr_wdata;
            psc_pkg::CSR_SENS_TEMP_SLOPE:   sens_slope_ff  <= csr_wdata;
            psc_pkg::CSR_OFFSET_TEMP_SLOPE: off_slope_ff   <= csr_wdata;
            psc_pkg::CSR_REFERENCE_TEMP:    ref_temp_ff    <= csr_wdata;
            psc_pkg::CSR_TEMP_SLOPE:        temp_slope_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // step counter with the pressure dispatch jump
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (run) begin
         unique case (uc.seq)
            psc_pkg::SEQ_NEXT:      step_in = step_ff + 1'b1;
            psc_pkg::SEQ_JUMP_PRES: step_in = (op_ff == psc_pkg::OP_PRESSURE) ?
                                              uc.target : step_ff + 1'b1;
            psc_pkg::SEQ_LAST:      busy_in = 1'b0;
            default:                busy_in = 1'b0;
         endcase
      end
   end

   // shared multiplier operands
   always_comb begin
      unique case (uc.a_sel)
         psc_pkg::A_RAW: mul_a = $signed({2'b00, raw_ff});
         default:        mul_a = dt_ff;
      endcase
      unique case (uc.b_sel)
         psc_pkg::B_OFFSET_SLOPE: mul_b = $signed({3'b000, off_slope_ff});
         psc_pkg::B_SENS_SLOPE:   mul_b = $signed({3'b000, sens_slope_ff});
         psc_pkg::B_SENS_LO:      mul_b = $signed({2'b00, sens_ff[16:0]});
         // sens is below 2^35 in magnitude, so its top 19 bits are floor(sens / 2^17)
         psc_pkg::B_SENS_HI:      mul_b = sens_ff[35:17];
         default:                 mul_b = $signed({3'b000, temp_slope_ff});
      endcase
   end

   // floor shifts of the product and accumulator
   assign prod_sh7  = prod_ff >>> 7;
   assign prod_sh8  = prod_ff >>> 8;
   assign prod_sh23 = prod_ff >>> 23;
   assign acc_sh15  = acc_ff >>> 15;
   assign acc_sh21  = acc_ff >>> 21;

   // datapath next values under the current control word
   always_comb begin
      dt_in   = dt_ff;
      prod_in = prod_ff;
      off_in  = off_ff;
      sens_in = sens_ff;
      acc_in  = acc_ff;
      result  = acc_sh15[31:0];
      if (uc.mul_en) begin
         prod_in = mul_a * mul_b;
      end
      unique case (uc.alu)
         psc_pkg::ALU_DT:
            // dT = raw - reference * 256
            dt_in = $signed({2'b00, raw_ff}) - $signed({2'b00, ref_temp_ff, 8'h00});
         psc_pkg::ALU_TEMP:
            result = prod_sh23[31:0] + TEMP_BASE_U;
         psc_pkg::ALU_OFF:
            off_in = $signed({4'h0, offset_base_ff, 16'h0000}) + prod_sh7[35:0];
         psc_pkg::ALU_SENS:
            sens_in = $signed({5'h00, sens_base_ff, 15'h0000}) + prod_sh8[35:0];
         psc_pkg::ALU_LOAD:
            acc_in = {{15{prod_ff[44]}}, prod_ff};
         psc_pkg::ALU_ADDHI:
            // raw * sens = raw * lo + (raw * hi) * 2^17
            acc_in = acc_ff + {prod_ff[42:0], 17'h00000};
         psc_pkg::ALU_SUBOFF:
            acc_in = acc_sh21 - {{24{off_ff[35]}}, off_ff};
         psc_pkg::ALU_FINAL:
            result = acc_sh15[31:0];
         default: ;
      endcase
   end

   // output register, freed as soon as the result is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         rsp_kind_in  = op_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         dt_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (run) begin
            dt_ff <= dt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_tuser;
         raw_ff <= req_tdata;
      end
      if (run) begin
         prod_ff <= prod_in;
         off_ff  <= off_in;
         sens_ff <= sens_in;
         acc_ff  <= acc_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
